/* sv/subscription_address_table_macros.svh */
// ----------------------------------------------------------------------------
// subscription address table assertion macros
// concurrent assertion shorthands clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef SUBSCRIPTION_ADDRESS_TABLE_MACROS_SVH
`define SUBSCRIPTION_ADDRESS_TABLE_MACROS_SVH

// same-cycle implication
`define SAT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("subscription address table check failed");

// next-cycle implication
`define SAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("subscription address table check failed");

`endif

/* sv/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// shared widths, codes and types of the subscription address table
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int MAX_DEPTH     = 64;
  localparam int DEPTH_DEFAULT = 8;
  localparam int IDX_W         = 6;
  localparam int OP_W          = 3;
  localparam int ADDR_W        = 16;
  localparam int STATUS_W      = 2;

  localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
  localparam logic [OP_W-1:0] OP_OVERWRITE  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE_ALL = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_SUCCESS     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd2;

  typedef struct packed {
    logic              active;
    logic              list;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic              match_seen;
    logic [IDX_W-1:0]  match_idx;
    logic              free_seen;
    logic [IDX_W-1:0]  free_idx;
    logic              last_seen;
    logic [IDX_W-1:0]  last_idx;
  } token_t;

  typedef struct packed {
    logic              clear_all;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_data;
  } upd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [ADDR_W-1:0]   listed_address;
    logic                entry_valid;
    logic                last;
  } word_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } emit_t;

endpackage

/* sv/sat_req_if.sv */
// ----------------------------------------------------------------------------
// sat_req_if
// request channel: operation and address words
// ----------------------------------------------------------------------------
interface sat_req_if;
  logic                          valid;
  logic                          ready;
  logic [sat_pkg::OP_W-1:0]      operation;
  logic [sat_pkg::ADDR_W-1:0]    address;

  modport source (output valid, output operation, output address, input ready);
  modport sink (input valid, input operation, input address, output ready);
endinterface

/* sv/sat_rsp_if.sv */
// ----------------------------------------------------------------------------
// sat_rsp_if
// response channel: status, lookup and list words
// ----------------------------------------------------------------------------
interface sat_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sat_pkg::STATUS_W-1:0]  status;
  logic                          found;
  logic [sat_pkg::ADDR_W-1:0]    listed_address;
  logic                          entry_valid;
  logic                          last;

  modport source (output valid, output status, output found, output listed_address,
                  output entry_valid, output last, input ready);
  modport sink (input valid, input status, input found, input listed_address,
                input entry_valid, input last, output ready);
endinterface

/* sv/subscription_address_table.sv */
// path: a request is registered into the head token, passes each cell's token
// stage, and its result word is loaded into the response register; a new request
// is taken only once the last has finished, as the token walks once along the row
// list: a second walk when any slot is in use; response back-pressure stalls it
// reset: all slots cleared to free, token row and response register emptied
// ----------------------------------------------------------------------------
// subscription_address_table
// group address filter table built as a row of slot cells scanned by a token
// ----------------------------------------------------------------------------
module subscription_address_table #(
  parameter int TABLE_DEPTH = sat_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sat_req_if.sink   req,
  sat_rsp_if.source rsp
);

  localparam int IdxW = sat_pkg::IDX_W;

  sat_pkg::token_t tok [TABLE_DEPTH+1];
  sat_pkg::emit_t  emit_cell [TABLE_DEPTH];
  sat_pkg::emit_t  emit_any;
  sat_pkg::upd_t   upd;
  logic            stall;

  sat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .tail  (tok[TABLE_DEPTH]),
    .emit  (emit_any),
    .head  (tok[0]),
    .stall (stall),
    .upd   (upd)
  );

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    localparam logic [IdxW-1:0] CellIdx = IdxW'(k);
    sat_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (CellIdx),
      .stall   (stall),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1]),
      .upd     (upd),
      .emit    (emit_cell[k])
    );
  end

  // only the cell holding the token can emit
  always_comb begin
    emit_any = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      emit_any = emit_any | emit_cell[k];
    end
  end

endmodule

/* sv/sat_cell.sv */
// ----------------------------------------------------------------------------
// sat_cell
// one table slot with a token stage that inspects the slot and passes on
// ----------------------------------------------------------------------------
module sat_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sat_pkg::IDX_W-1:0]  idx,
  input  logic                       stall,
  input  sat_pkg::token_t            tok_in,
  output sat_pkg::token_t            tok_out,
  input  sat_pkg::upd_t              upd,
  output sat_pkg::emit_t             emit
);

  logic [sat_pkg::ADDR_W-1:0] slot;
  sat_pkg::token_t            tok_next;
  logic                       nz;

  assign nz = (slot != '0);

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.list) begin
      if (!tok_in.match_seen && slot == tok_in.addr) begin
        tok_next.match_seen = 1'b1;
        tok_next.match_idx  = idx;
      end
      if (!tok_in.free_seen && !nz) begin
        tok_next.free_seen = 1'b1;
        tok_next.free_idx  = idx;
      end
      if (nz) begin
        tok_next.last_seen = 1'b1;
        tok_next.last_idx  = idx;
      end
    end
  end

  always_comb begin
    emit = '0;
    if (tok_in.active && tok_in.list && nz) begin
      emit.valid               = 1'b1;
      emit.word.status         = sat_pkg::ST_SUCCESS;
      emit.word.listed_address = slot;
      emit.word.entry_valid    = 1'b1;
      emit.word.last           = (idx == tok_in.last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (!stall) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (upd.wr_en && upd.wr_idx == idx) begin
      slot <= upd.wr_data;
    end else if (upd.clear_all) begin
      slot <= '0;
    end
  end

endmodule

/* sv/sat_ctrl.sv */
// ----------------------------------------------------------------------------
// sat_ctrl
// launches tokens into the cell row, decides table updates, holds the
// response register
// ----------------------------------------------------------------------------
module sat_ctrl (
  input  logic            clk,
  input  logic            rst,
  sat_req_if.sink         req,
  sat_rsp_if.source       rsp,
  input  sat_pkg::token_t tail,
  input  sat_pkg::emit_t  emit,
  output sat_pkg::token_t head,
  output logic            stall,
  output sat_pkg::upd_t   upd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  state_t          state;
  state_t          state_next;
  sat_pkg::token_t head_next;
  sat_pkg::word_t  oword;
  sat_pkg::word_t  fin_word;
  sat_pkg::upd_t   fin_upd;
  logic            ovalid;
  logic            accept;
  logic            out_free;
  logic            fin;
  logic            list_end;
  logic            relaunch;
  logic            need_out;
  logic            load_out;

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign out_free  = !ovalid || rsp.ready;

  assign fin      = tail.active && !tail.list;
  assign list_end = tail.active && tail.list;

  always_comb begin
    fin_word      = '0;
    fin_word.last = 1'b1;
    fin_upd       = '0;
    relaunch      = 1'b0;
    case (tail.op)
      sat_pkg::OP_ADD: begin
        if (!tail.match_seen) begin
          if (tail.free_seen) begin
            fin_upd.wr_en   = 1'b1;
            fin_upd.wr_idx  = tail.free_idx;
            fin_upd.wr_data = tail.addr;
          end else begin
            fin_word.status = sat_pkg::ST_FULL;
          end
        end
      end
      sat_pkg::OP_REMOVE: begin
        if (tail.match_seen) begin
          fin_upd.wr_en  = 1'b1;
          fin_upd.wr_idx = tail.match_idx;
        end else begin
          fin_word.status = sat_pkg::ST_NOT_PRESENT;
        end
      end
      sat_pkg::OP_OVERWRITE: begin
        fin_upd.clear_all = 1'b1;
        fin_upd.wr_en     = 1'b1;
        fin_upd.wr_data   = tail.addr;
      end
      sat_pkg::OP_DELETE_ALL: begin
        fin_upd.clear_all = 1'b1;
      end
      sat_pkg::OP_LOOKUP: begin
        fin_word.found = (tail.addr != '0) && tail.match_seen;
      end
      sat_pkg::OP_LIST: begin
        relaunch = tail.last_seen;
      end
      default: begin
      end
    endcase
  end

  assign need_out = fin && !relaunch;
  assign stall    = (emit.valid || need_out) && !out_free;
  assign load_out = !stall && (emit.valid || need_out);
  assign upd      = (fin && !stall) ? fin_upd : '0;

  always_comb begin
    head_next = '0;
    if (accept) begin
      head_next.active = 1'b1;
      head_next.op     = req.operation;
      head_next.addr   = req.address;
    end else if (fin && relaunch) begin
      head_next        = tail;
      head_next.list   = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if ((need_out && !stall) || list_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (!stall) begin
        head <= head_next;
      end
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      oword <= emit.valid ? emit.word : fin_word;
    end
  end

  assign rsp.valid          = ovalid;
  assign rsp.status         = oword.status;
  assign rsp.found          = oword.found;
  assign rsp.listed_address = oword.listed_address;
  assign rsp.entry_valid    = oword.entry_valid;
  assign rsp.last           = oword.last;

endmodule

/* sv/sat_checker.sv */
// ----------------------------------------------------------------------------
// sat_checker
// port-level checks of the subscription address table, bound to the top
// ----------------------------------------------------------------------------
`include "subscription_address_table_macros.svh"

module sat_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [sat_pkg::STATUS_W-1:0] rsp_status,
  input logic                         rsp_found,
  input logic [sat_pkg::ADDR_W-1:0]   rsp_listed_address,
  input logic                         rsp_entry_valid,
  input logic                         rsp_last
);

  `SAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  `SAT_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

  `SAT_ASSERT_SAME(a_entry_word, rsp_valid && rsp_entry_valid, rsp_status == sat_pkg::ST_SUCCESS && !rsp_found && rsp_listed_address != '0)

  `SAT_ASSERT_SAME(a_plain_word, rsp_valid && !rsp_entry_valid, rsp_last && rsp_listed_address == '0)

endmodule

bind subscription_address_table sat_checker u_sat_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found          (rsp.found),
  .rsp_listed_address (rsp.listed_address),
  .rsp_entry_valid    (rsp.entry_valid),
  .rsp_last           (rsp.last)
);
